### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL.
// Clocked on clk_i; the checked form is skipped while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### rtl/core/tpa_pkg.sv
// ----------------------------------------------------------------------------
// tpa_pkg
// Constants shared by the two-point angle block: widths, arctangent table,
// pre-rotation angle, degree factor and unit codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tpa_pkg;

  localparam int COORD_WIDTH_DEF  = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  // Angle accumulator: radians * 2^28.
  localparam int ZW        = 32;
  localparam int TABLE_LEN = 24;
  localparam int AW        = 16;   // result width

  localparam logic signed [ZW-1:0] HALF_PI_FIXED = 32'sd421657428;

  // round(180/pi * 2^20)
  localparam int DEG_W = 27;
  localparam logic signed [DEG_W-1:0] DEG_FACTOR = 27'sd60078979;
  localparam int PW = ZW + DEG_W;

  // Rounding cut points: radians drop 16 bits, degrees drop 42.
  localparam int RAD_LSB = 15;
  localparam int DEG_LSB = 41;

  localparam logic UNIT_RAD = 1'b0;
  localparam logic UNIT_DEG = 1'b1;

  // round(atan(2^-k) * 2^28)
  localparam logic signed [ZW-1:0] ATAN_TABLE [TABLE_LEN] = '{
    32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
    32'sd16755422,  32'sd8385879,   32'sd4193963,  32'sd2097109,
    32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
    32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192,
    32'sd4096,      32'sd2048,      32'sd1024,     32'sd512,
    32'sd256,       32'sd128,       32'sd64,       32'sd32
  };

endpackage

### rtl/core/two_point_angle_top.sv
// From input beat to output valid, each beat passes these registers in order:
//   difference, pre-rotation, one stage per CORDIC step, degree multiply, output.
// Throughput: one beat per cycle unless the output buffer is full.
// A two-entry output buffer keeps the input open while one result waits.
// Reset (rst_ni low, async): valids clear, unit_q returns to radians.
// ----------------------------------------------------------------------------
// two_point_angle_top
// atan2(x1-x2, y2-y1) of two points by a pipelined vectoring CORDIC, in
// radians (Q3.12) or degrees (Q9.6); flags coincident points.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module two_point_angle_top #(
  parameter int COORD_WIDTH  = tpa_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STEPS = tpa_pkg::CORDIC_STEPS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] first_x_i,
  input  logic signed [COORD_WIDTH-1:0] first_y_i,
  input  logic signed [COORD_WIDTH-1:0] second_x_i,
  input  logic signed [COORD_WIDTH-1:0] second_y_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [tpa_pkg::AW-1:0] angle_o,
  output logic                          points_equal_o
);
  import tpa_pkg::*;

  localparam int NSTEP = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
  localparam int DW    = COORD_WIDTH + 1;   // difference
  localparam int XW    = COORD_WIDTH + 4;   // room for CORDIC gain and sqrt(2)
  localparam int RW    = AW + 1;            // rounding sum

  logic unit_q;
  logic en;

  // Output buffer
  logic                 out_v_q, skid_v_q;
  logic signed [AW-1:0] out_angle_q, skid_angle_q;
  logic                 out_eq_q, skid_eq_q;

  // Difference stage
  logic                 s1_v_q;
  logic signed [DW-1:0] s1_i_q, s1_j_q;

  // CORDIC stages: index 0 is the pre-rotated vector
  logic                 c_v_q  [NSTEP+1];
  logic signed [XW-1:0] c_x_q  [NSTEP+1];
  logic signed [XW-1:0] c_y_q  [NSTEP+1];
  logic signed [ZW-1:0] c_z_q  [NSTEP+1];
  logic                 c_eq_q [NSTEP+1];

  // Multiply stage
  logic                 m_v_q, m_eq_q;
  logic signed [ZW-1:0] m_z_q;
  logic signed [PW-1:0] m_p_q;

  // Whole pipeline moves together; stops only when the output buffer is full.
  assign en         = !skid_v_q;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_q <= UNIT_RAD;
    end else if (cfg_we_i) begin
      unit_q <= cfg_wdata_i;
    end
  end

  // ---- difference stage ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_i_q <= {first_x_i[COORD_WIDTH-1], first_x_i}
              - {second_x_i[COORD_WIDTH-1], second_x_i};
      s1_j_q <= {second_y_i[COORD_WIDTH-1], second_y_i}
              - {first_y_i[COORD_WIDTH-1], first_y_i};
    end
  end

  // ---- pre-rotation: vector (x=j, y=i) folded into the right half-plane ----
  logic signed [XW-1:0] pr_x, pr_y, pr_x_d, pr_y_d;
  logic signed [ZW-1:0] pr_z_d;

  assign pr_x = {{(XW-DW){s1_j_q[DW-1]}}, s1_j_q};
  assign pr_y = {{(XW-DW){s1_i_q[DW-1]}}, s1_i_q};

  always_comb begin
    pr_x_d = pr_x;
    pr_y_d = pr_y;
    pr_z_d = '0;
    if (pr_x[XW-1]) begin
      if (!pr_y[XW-1]) begin
        pr_x_d = pr_y;
        pr_y_d = -pr_x;
        pr_z_d = HALF_PI_FIXED;
      end else begin
        pr_x_d = -pr_y;
        pr_y_d = pr_x;
        pr_z_d = -HALF_PI_FIXED;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q[0] <= 1'b0;
    end else if (en) begin
      c_v_q[0] <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_x_q[0]  <= pr_x_d;
      c_y_q[0]  <= pr_y_d;
      c_z_q[0]  <= pr_z_d;
      c_eq_q[0] <= (s1_i_q == '0) && (s1_j_q == '0);
    end
  end

  // ---- CORDIC steps, one per stage ----
  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    logic signed [XW-1:0] x_sh, y_sh;

    assign x_sh = c_x_q[k] >>> k;
    assign y_sh = c_y_q[k] >>> k;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        c_v_q[k+1] <= 1'b0;
      end else if (en) begin
        c_v_q[k+1] <= c_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        c_eq_q[k+1] <= c_eq_q[k];
        if (!c_y_q[k][XW-1]) begin
          c_x_q[k+1] <= c_x_q[k] + y_sh;
          c_y_q[k+1] <= c_y_q[k] - x_sh;
          c_z_q[k+1] <= c_z_q[k] + ATAN_TABLE[k];
        end else begin
          c_x_q[k+1] <= c_x_q[k] - y_sh;
          c_y_q[k+1] <= c_y_q[k] + x_sh;
          c_z_q[k+1] <= c_z_q[k] - ATAN_TABLE[k];
        end
      end
    end
  end

  // ---- degree multiply ----
  logic signed [PW-1:0] m_p_d;

  assign m_p_d = PW'(c_z_q[NSTEP]) * PW'(DEG_FACTOR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else if (en) begin
      m_v_q <= c_v_q[NSTEP];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_z_q  <= c_z_q[NSTEP];
      m_p_q  <= m_p_d;
      m_eq_q <= c_eq_q[NSTEP];
    end
  end

  // ---- rounding (ties toward +inf) and unit select ----
  logic [RW-1:0]        rad_sum, deg_sum;
  logic signed [AW-1:0] fin_angle;
  logic                 fin_v;

  assign rad_sum = m_z_q[RAD_LSB +: RW] + RW'(1);
  assign deg_sum = m_p_q[DEG_LSB +: RW] + RW'(1);

  always_comb begin
    if (m_eq_q) begin
      fin_angle = '0;
    end else if (unit_q == UNIT_DEG) begin
      fin_angle = deg_sum[RW-1:1];
    end else begin
      fin_angle = rad_sum[RW-1:1];
    end
  end

  assign fin_v = m_v_q && en;

  // ---- output register plus skid entry ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_ready_i || !out_v_q) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q  <= fin_v;
      end
    end else if (fin_v) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready_i || !out_v_q) begin
      if (skid_v_q) begin
        out_angle_q <= skid_angle_q;
        out_eq_q    <= skid_eq_q;
      end else if (fin_v) begin
        out_angle_q <= fin_angle;
        out_eq_q    <= m_eq_q;
      end
    end else if (fin_v) begin
      skid_angle_q <= fin_angle;
      skid_eq_q    <= m_eq_q;
    end
  end

  assign out_valid_o    = out_v_q;
  assign angle_o        = out_angle_q;
  assign points_equal_o = out_eq_q;

  // ---- checks ----
  `ASSERT_CLK(a_skid_needs_out, !skid_v_q || out_v_q, "skid entry full with output empty")
  `ASSERT_CLK(a_skid_drains, (out_v_q && out_ready_i && skid_v_q) |=> (out_v_q && !skid_v_q),
              "skid beat not moved to output")
  `ASSERT_CLK(a_eq_zero, (out_v_q && points_equal_o) |-> (angle_o == '0),
              "equal points with nonzero angle")
  `ASSERT_CLK(a_freeze, skid_v_q |=> ($stable(m_v_q) && $stable(c_v_q[NSTEP])),
              "pipeline moved while output buffer full")

endmodule

### tb/sv/tb_two_point_angle_top.sv
// ----------------------------------------------------------------------------
// tb_two_point_angle_top
// Self-checking bench for the two-point angle block. Point pairs go in over
// a valid/ready channel; a scoreboard predicts each CORDIC atan2 angle and
// the coincident-point flag from its own bit-accurate model and checks every
// output beat in order. Runs directed corner pairs in both units, then random
// pairs under several sender/receiver idle mixes and a long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_two_point_angle_top;

  localparam int CW         = tpa_pkg::COORD_WIDTH_DEF;
  localparam int STEPS      = tpa_pkg::CORDIC_STEPS_DEF;
  localparam int RAND_ITEMS = 100;     // per phase, eight phases
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT = 2 * (STEPS + 4);
  localparam int LIMIT      = 300000;

  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  // Angle accumulator scale: radians * 2^28.
  localparam longint HALF_PI_Q28 = 64'sd421657428;
  localparam longint DEG_SCALE   = 64'sd60078979;   // round(180/pi * 2^20)
  localparam longint ATAN_Q28 [24] = '{
    210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
    4193963, 2097109, 1048571, 524287, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048,
    1024, 512, 256, 128, 64, 32
  };

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    logic signed [tpa_pkg::AW-1:0] angle;
    logic                          points_equal;
  } angle_result_t;

  class angle_scoreboard;
    angle_result_t pending_q[$];
    logic          unit;
    int            mismatches;

    function new();
      unit       = tpa_pkg::UNIT_RAD;
      mismatches = 0;
    endfunction

    function void set_unit(logic u);
      unit = u;
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    function angle_result_t predict_angle(coord_t fx, coord_t fy, coord_t sx, coord_t sy);
      longint di, dj, x, y, z, t, dx, dy, a;
      int n;
      angle_result_t r;
      di = longint'(fx) - longint'(sx);
      dj = longint'(sy) - longint'(fy);
      r.angle        = '0;
      r.points_equal = 1'b1;
      if (di == 0 && dj == 0) return r;
      // Vector (x, y) = (j, i); pre-rotate left half-plane by a quarter turn.
      x = dj;
      y = di;
      z = 0;
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x = y;
          y = -t;
          z = HALF_PI_Q28;
        end else begin
          x = -y;
          y = t;
          z = -HALF_PI_Q28;
        end
      end
      n = (STEPS > 24) ? 24 : STEPS;
      for (int k = 0; k < n; k++) begin
        dx = y >>> k;
        dy = x >>> k;
        if (y >= 0) begin
          x = x + dx;
          y = y - dy;
          z = z + ATAN_Q28[k];
        end else begin
          x = x - dx;
          y = y + dy;
          z = z - ATAN_Q28[k];
        end
      end
      if (unit == tpa_pkg::UNIT_DEG) a = (z * DEG_SCALE + (longint'(1) << 41)) >>> 42;
      else a = (z + (longint'(1) << 15)) >>> 16;
      r.angle        = a[tpa_pkg::AW-1:0];
      r.points_equal = 1'b0;
      return r;
    endfunction

    function void note_points(coord_t fx, coord_t fy, coord_t sx, coord_t sy);
      pending_q.push_back(predict_angle(fx, fy, sx, sy));
    endfunction

    function void check_angle(logic signed [tpa_pkg::AW-1:0] ang, logic eq);
      angle_result_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result beat: angle %0d points_equal %0b", ang, eq);
        mismatches++;
        return;
      end
      e = pending_q.pop_front();
      if (ang !== e.angle) begin
        $error("angle: expected %0d, got %0d", e.angle, ang);
        mismatches++;
      end
      if (eq !== e.points_equal) begin
        $error("points_equal: expected %0b, got %0b", e.points_equal, eq);
        mismatches++;
      end
    endfunction
  endclass

  logic   clk_i          = 1'b0;
  logic   rst_ni         = 1'b0;
  logic   cfg_we_i       = 1'b0;
  logic   cfg_wdata_i    = 1'b0;
  logic   in_valid_i     = 1'b0;
  logic   in_ready_o;
  coord_t first_x_i      = '0;
  coord_t first_y_i      = '0;
  coord_t second_x_i     = '0;
  coord_t second_y_i     = '0;
  logic   out_valid_o;
  logic   out_ready_i    = 1'b0;
  logic signed [tpa_pkg::AW-1:0] angle_o;
  logic   points_equal_o;

  int     send_idle_pct  = 0;
  int     stall_pct      = 0;
  logic   hold_arm       = 1'b0;
  logic   hold_done      = 1'b0;
  int     hold_left      = 0;

  angle_scoreboard sb = new();

  two_point_angle_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .first_x_i      (first_x_i),
    .first_y_i      (first_y_i),
    .second_x_i     (second_x_i),
    .second_y_i     (second_y_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .angle_o        (angle_o),
    .points_equal_o (points_equal_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Receiver: random stalls, plus one long hold-off counted here.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (hold_arm && !hold_done) begin
      out_ready_i <= 1'b0;
      hold_left   <= HOLD_CYCLES;
      hold_done   <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Output beats are checked at the edge that accepts them.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_angle(angle_o, points_equal_o);
  end

  initial begin
    int cyc;
    cyc = 0;
    while (cyc < LIMIT) begin
      @(posedge clk_i);
      cyc++;
    end
    $display("TEST FAILED");
    $finish;
  end

  task automatic write_unit(logic u);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= u;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_unit(u);
  endtask

  task automatic send_points(coord_t fx, coord_t fy, coord_t sx, coord_t sy);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    first_x_i  <= fx;
    first_y_i  <= fy;
    second_x_i <= sx;
    second_y_i <= sy;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_points(fx, fy, sx, sy);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic corner_pairs();
    send_points(0, 0, 0, 0);                 // coincident
    send_points(CMIN, CMIN, CMIN, CMIN);     // coincident at the extreme
    send_points(0, 1, 0, 0);                 // i zero, j negative: +pi
    send_points(0, 0, 0, 5);                 // i zero, j positive
    send_points(3, 0, 0, 0);                 // j zero, i positive
    send_points(-3, 7, 0, 7);                // j zero, i negative
    send_points(CMAX, CMIN, CMIN, CMAX);     // largest i and j
    send_points(CMIN, CMAX, CMAX, CMIN);     // most negative i and j
    send_points(CMAX, CMAX, CMIN, CMIN);
    send_points(CMIN, CMIN, CMAX, CMAX);
    send_points(0, CMAX, 1, CMIN);           // just above -pi
    send_points(1, CMAX, 0, CMIN);           // just below +pi
  endtask

  function automatic coord_t pick_extreme();
    case ($urandom_range(0, 4))
      0: return CMIN;
      1: return CMAX;
      2: return '1;
      3: return coord_t'(1);
      default: return '0;
    endcase
  endfunction

  task automatic random_pair();
    coord_t fx, fy, sx, sy;
    int d, e;
    fx = coord_t'($urandom);
    fy = coord_t'($urandom);
    sx = coord_t'($urandom);
    sy = coord_t'($urandom);
    d  = $urandom_range(0, 8) - 4;
    e  = $urandom_range(0, 8) - 4;
    case ($urandom_range(0, 9))
      5: begin                               // nearby points
        sx = fx + coord_t'(d);
        sy = fy + coord_t'(e);
      end
      6: begin                               // one difference zero
        if ($urandom_range(0, 1)) sx = fx;
        else sy = fy;
      end
      7: begin
        sx = fx;
        sy = fy;
      end
      8: begin
        fx = pick_extreme();
        fy = pick_extreme();
        sx = pick_extreme();
        sy = pick_extreme();
      end
      9: begin                               // diagonals, |i| == |j|
        sx = fx - coord_t'(d);
        sy = fy + coord_t'(($urandom_range(0, 1)) ? d : -d);
      end
      default: ;
    endcase
    send_points(fx, fy, sx, sy);
  endtask

  initial begin
    int mode;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_unit(tpa_pkg::UNIT_DEG);
    corner_pairs();
    drain();
    write_unit(tpa_pkg::UNIT_RAD);
    corner_pairs();
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      mode = ph / 2;
      case (mode)
        0: begin
          send_idle_pct = 0;
          stall_pct    <= 0;
        end
        1: begin
          send_idle_pct = 56;
          stall_pct    <= 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct    <= 56;
        end
        default: begin
          send_idle_pct = 28;
          stall_pct    <= 28;
        end
      endcase
      write_unit((ph % 2) ? tpa_pkg::UNIT_RAD : tpa_pkg::UNIT_DEG);
      if (ph == 0) hold_arm <= 1'b1;   // fill the pipe against a held receiver
      repeat (RAND_ITEMS) random_pair();
      drain();
    end

    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
